// ----- src/dss_pkg.sv -----
// Shared types and codes for the two-stack shared memory block.
package dss_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_PUSH_LO = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_UP = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_LO  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_UP  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    localparam logic signed [WORD_W-1:0] POP_EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic signed [WORD_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] pop_value;
        logic [STATUS_W-1:0]      status;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // request taken this cycle
        logic load_now;   // result known at accept (push or empty pop)
        logic load_read;  // result is the word read on the previous cycle
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic lower_empty;
        logic upper_empty;
    } t_dp_sts;

endpackage

// ----- src/dss_ctrl.sv -----
// Controller: handshakes and sequencing of the two-stack block.
module dss_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [dss_pkg::OPCODE_W-1:0] i_opcode,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  dss_pkg::t_dp_sts          i_sts,
    output dss_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_needs_read;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    // a pop from a non-empty stack waits in S_READ for the registered memory read
    always_comb begin
        case (i_opcode)
            dss_pkg::OP_POP_LO: w_needs_read = !i_sts.lower_empty;
            dss_pkg::OP_POP_UP: w_needs_read = !i_sts.upper_empty;
            default:            w_needs_read = 1'b0;
        endcase
    end

    assign o_cmd.accept    = w_accept;
    assign o_cmd.load_now  = w_accept && !w_needs_read;
    assign o_cmd.load_read = (r_state == S_READ);
    assign o_out_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_needs_read) begin
                        r_state <= S_READ;
                    end
                    // drop a taken result unless a new one lands at this edge
                    if (w_accept && !w_needs_read) begin
                        r_out_valid <= 1'b1;
                    end else if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/dss_dp.sv -----
// Datapath: stack counts, shared memory and result register.
module dss_dp #(
    parameter int unsigned DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dss_pkg::t_in_item i_in_item,
    input  dss_pkg::t_dp_cmd  i_cmd,
    output dss_pkg::t_dp_sts  o_sts,
    output dss_pkg::t_out_item o_out_item
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_M1  = CW'(DEPTH - 1);
    localparam logic [CW-1:0] ONE_C     = CW'(1);
    localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(DEPTH);

    logic signed [dss_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic signed [dss_pkg::WORD_W-1:0] r_rd_data;
    logic [CW-1:0]          r_lower_cnt;
    logic [CW-1:0]          r_upper_cnt;
    logic [CW-1:0]          n_lower_cnt;
    logic [CW-1:0]          n_upper_cnt;
    dss_pkg::t_out_item     r_out;
    dss_pkg::t_out_item     n_out;
    logic [CW:0]            w_sum;
    logic                   w_wr_en;
    logic [CW-1:0]          w_wr_addr;
    logic                   w_rd_en;
    logic [CW-1:0]          w_rd_addr;

    assign w_sum = {1'b0, r_lower_cnt} + {1'b0, r_upper_cnt};

    assign o_sts.full        = (w_sum >= DEPTH_EXT);
    assign o_sts.lower_empty = (r_lower_cnt == '0);
    assign o_sts.upper_empty = (r_upper_cnt == '0);

    always_comb begin
        n_lower_cnt     = r_lower_cnt;
        n_upper_cnt     = r_upper_cnt;
        w_wr_en         = 1'b0;
        w_wr_addr       = r_lower_cnt;
        w_rd_en         = 1'b0;
        w_rd_addr       = r_lower_cnt - ONE_C;
        n_out.pop_value = '0;
        n_out.status    = dss_pkg::ST_OK;
        case (i_in_item.opcode)
            dss_pkg::OP_PUSH_LO: begin
                w_wr_addr = r_lower_cnt;
                if (o_sts.full) begin
                    n_out.status = dss_pkg::ST_OVERFLOW;
                end else begin
                    w_wr_en     = i_cmd.accept;
                    n_lower_cnt = r_lower_cnt + ONE_C;
                end
            end
            dss_pkg::OP_PUSH_UP: begin
                w_wr_addr = DEPTH_M1 - r_upper_cnt;
                if (o_sts.full) begin
                    n_out.status = dss_pkg::ST_OVERFLOW;
                end else begin
                    w_wr_en     = i_cmd.accept;
                    n_upper_cnt = r_upper_cnt + ONE_C;
                end
            end
            dss_pkg::OP_POP_LO: begin
                w_rd_addr = r_lower_cnt - ONE_C;
                if (o_sts.lower_empty) begin
                    n_out.pop_value = dss_pkg::POP_EMPTY_VALUE;
                    n_out.status    = dss_pkg::ST_UNDERFLOW;
                end else begin
                    w_rd_en     = i_cmd.accept;
                    n_lower_cnt = r_lower_cnt - ONE_C;
                end
            end
            dss_pkg::OP_POP_UP: begin
                w_rd_addr = DEPTH_C - r_upper_cnt;
                if (o_sts.upper_empty) begin
                    n_out.pop_value = dss_pkg::POP_EMPTY_VALUE;
                    n_out.status    = dss_pkg::ST_UNDERFLOW;
                end else begin
                    w_rd_en     = i_cmd.accept;
                    n_upper_cnt = r_upper_cnt - ONE_C;
                end
            end
            default: begin
                n_out.status = dss_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_cnt <= '0;
            r_upper_cnt <= '0;
        end else if (i_cmd.accept) begin
            r_lower_cnt <= n_lower_cnt;
            r_upper_cnt <= n_upper_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr[AW-1:0]] <= i_in_item.push_value;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_now) begin
            r_out <= n_out;
        end else if (i_cmd.load_read) begin
            r_out.pop_value <= r_rd_data;
            r_out.status    <= dss_pkg::ST_OK;
        end
    end

    assign o_out_item = r_out;

endmodule

// ----- src/dual_stack_shared_memory.sv -----
// Top level: two stacks in one shared memory, push/pop requests in, results out.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_item  (opcode, push_value)
//  out     | output    | o_out_valid/ i_out_ready| o_out_item (pop_value, status)
//
// For a push, and a pop from an empty stack, the result is registered at the
// accept edge. For a pop from a non-empty stack the word passes first through
// the registered read port of the shared memory, then into the result register.
// Synchronous active-low reset clears both stack counts and the handshake
// state; memory contents are not cleared. A request is accepted while a
// result is held only if that result is taken in the same cycle.
module dual_stack_shared_memory #(
    parameter int unsigned DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dss_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dss_pkg::t_out_item o_out_item
);

    dss_pkg::t_dp_cmd w_cmd;
    dss_pkg::t_dp_sts w_sts;

    dss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_in_item.opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    dss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_item (o_out_item)
    );

endmodule

// ----- src/dss_checker.sv -----
// Port-level checker for the two-stack block, bound to the top level.
module dss_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input dss_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input dss_pkg::t_out_item o_out_item
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && o_in_ready;

    // held result must not change until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // a new result rises only after an accepted request, directly or through the memory read
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_in_acc) || $past(w_in_acc, 2))
        else $error("result without a request");

    // no request taken while a stalled result is held
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request accepted over a held result");

    // refusals carry their fixed values
    a_fail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_item.status == dss_pkg::ST_OK) ||
            ((o_out_item.status == dss_pkg::ST_OVERFLOW) &&
             (o_out_item.pop_value == '0)) ||
            ((o_out_item.status == dss_pkg::ST_UNDERFLOW) &&
             (o_out_item.pop_value == dss_pkg::POP_EMPTY_VALUE)))
        else $error("bad status or value on refusal");

    // reset drops any result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind dual_stack_shared_memory dss_checker u_dss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ----- bench/dual_stack_shared_memory_tb.sv -----
// Testbench for the two-stack shared memory: directed and random push/pop traffic checked against a model.
module dual_stack_shared_memory_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dss_pkg::*;

    localparam int unsigned DEPTH = 64;
    localparam int unsigned RANDOM_OPS = 1700;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PRINT_CAP = 40;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    dual_stack_shared_memory #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    t_in_item    queued_stack_ops[$];
    t_out_item   predicted_replies[$];
    logic [31:0] model_words[DEPTH];
    int unsigned lower_used = 0;
    int unsigned upper_used = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    logic        request_taken = 1'b0;

    int unsigned req_gap = 0;
    int unsigned req_mode_left = 0;
    logic        req_calm = 1'b1;
    int unsigned resp_stall = 0;
    int unsigned resp_mode_left = 0;
    logic        resp_calm = 1'b0;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_op(input logic [OPCODE_W-1:0] op, input logic [31:0] value);
        t_in_item req;
        req.opcode = op;
        req.push_value = value;
        queued_stack_ops.push_back(req);
    endtask

    // Apply one request to the model stacks and return the reply it produces.
    function automatic t_out_item apply_stack_op(input t_in_item req);
        t_out_item reply;
        logic      full;
        reply.pop_value = '0;
        reply.status = ST_OK;
        full = (lower_used + upper_used) >= DEPTH;
        case (req.opcode)
            OP_PUSH_LO: begin
                if (full) begin
                    reply.status = ST_OVERFLOW;
                end else begin
                    model_words[lower_used] = req.push_value;
                    lower_used++;
                end
            end
            OP_PUSH_UP: begin
                if (full) begin
                    reply.status = ST_OVERFLOW;
                end else begin
                    model_words[DEPTH - 1 - upper_used] = req.push_value;
                    upper_used++;
                end
            end
            OP_POP_LO: begin
                if (lower_used == 0) begin
                    reply.pop_value = POP_EMPTY_VALUE;
                    reply.status = ST_UNDERFLOW;
                end else begin
                    lower_used--;
                    reply.pop_value = model_words[lower_used];
                end
            end
            default: begin
                if (upper_used == 0) begin
                    reply.pop_value = POP_EMPTY_VALUE;
                    reply.status = ST_UNDERFLOW;
                end else begin
                    reply.pop_value = model_words[DEPTH - upper_used];
                    upper_used--;
                end
            end
        endcase
        return reply;
    endfunction

    // Request side: hold valid and payload until taken, then load the next request, with random gaps in busy stretches.
    always @(negedge i_clk) begin
        logic     nxt_valid;
        t_in_item nxt_item;
        nxt_valid = i_in_valid;
        nxt_item = i_in_item;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (req_mode_left == 0) begin
                req_calm = ~req_calm;
                req_mode_left = $urandom_range(40, 400);
            end else begin
                req_mode_left--;
            end
            if (i_in_valid && request_taken) begin
                nxt_valid = 1'b0;
                if (!req_calm && $urandom_range(0, 2) == 0) begin
                    req_gap = pick_gap();
                end
            end
            if (!nxt_valid) begin
                if (req_gap > 0) begin
                    req_gap--;
                end else if (queued_stack_ops.size() != 0) begin
                    nxt_item = queued_stack_ops.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_item <= nxt_item;
    end

    // Reply side: random back-pressure, with calm stretches of steady ready.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (resp_mode_left == 0) begin
                resp_calm = ~resp_calm;
                resp_mode_left = $urandom_range(40, 400);
            end else begin
                resp_mode_left--;
            end
            if (resp_stall > 0) begin
                resp_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!resp_calm && $urandom_range(0, 3) == 0) begin
                    resp_stall = pick_gap();
                end
            end
        end
    end

    // Check replies first, then predict for the request taken at this edge.
    always @(posedge i_clk) begin
        t_out_item want;
        request_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_replies.size() == 0) begin
                    report_mismatch($sformatf("reply with none pending: value %0d status %0d",
                                              o_out_item.pop_value, o_out_item.status));
                end else begin
                    want = predicted_replies.pop_front();
                    if (o_out_item.pop_value !== want.pop_value) begin
                        report_mismatch($sformatf("pop_value %0d, expected %0d",
                                                  o_out_item.pop_value, want.pop_value));
                    end
                    if (o_out_item.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_out_item.status, want.status));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                predicted_replies.push_back(apply_stack_op(i_in_item));
                request_taken = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** dual_stack_shared_memory: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [OPCODE_W-1:0] all_ops[4];
        logic [OPCODE_W-1:0] op;
        logic [OPCODE_W-1:0] push_side;
        logic [OPCODE_W-1:0] pop_side;
        int unsigned         random_ops;
        int unsigned         phase_kind;
        int unsigned         phase_len;
        int unsigned         roll;

        all_ops = '{OP_PUSH_LO, OP_PUSH_UP, OP_POP_LO, OP_POP_UP};

        // Directed: empty pops, word extremes, LIFO order, push then immediate pop.
        queue_op(OP_POP_LO, 32'h1234_5678);
        queue_op(OP_POP_UP, 32'hFFFF_FFFF);
        queue_op(OP_PUSH_LO, 32'h7FFF_FFFF);
        queue_op(OP_PUSH_LO, 32'h8000_0000);
        queue_op(OP_PUSH_LO, 32'hAAAA_AAAA);
        queue_op(OP_PUSH_UP, 32'h0000_0000);
        queue_op(OP_PUSH_UP, 32'hFFFF_FFFF);
        queue_op(OP_PUSH_UP, 32'h5555_5555);
        queue_op(OP_POP_LO, 32'h0000_0000);
        queue_op(OP_POP_UP, 32'h8000_0000);
        queue_op(OP_PUSH_LO, 32'h0000_0001);
        queue_op(OP_POP_LO, 32'h7FFF_FFFF);
        queue_op(OP_POP_LO, 32'hFFFF_FFFF);
        queue_op(OP_POP_LO, 32'h5555_5555);
        queue_op(OP_POP_LO, 32'hAAAA_AAAA);
        queue_op(OP_PUSH_UP, 32'hDEAD_BEEF);
        queue_op(OP_POP_UP, 32'h0000_0000);
        queue_op(OP_POP_UP, 32'h0000_0000);
        queue_op(OP_POP_UP, 32'h0000_0000);
        queue_op(OP_POP_UP, 32'h0000_0000);

        // Random phases: mixed traffic, fill to overflow, drain to underflow, one-sided fill.
        random_ops = 0;
        while (random_ops < RANDOM_OPS) begin
            phase_kind = $urandom_range(0, 3);
            phase_len = (phase_kind == 0) ? $urandom_range(20, 60) : $urandom_range(70, 120);
            push_side = $urandom_range(0, 1) ? OP_PUSH_UP : OP_PUSH_LO;
            pop_side = (push_side == OP_PUSH_UP) ? OP_POP_UP : OP_POP_LO;
            for (int k = 0; k < phase_len; k++) begin
                roll = $urandom_range(0, 99);
                case (phase_kind)
                    0: op = all_ops[$urandom_range(0, 3)];
                    1: op = (roll < 88) ? all_ops[$urandom_range(0, 1)]
                                        : all_ops[$urandom_range(2, 3)];
                    2: op = (roll < 88) ? all_ops[$urandom_range(2, 3)]
                                        : all_ops[$urandom_range(0, 1)];
                    default: op = (roll < 85) ? push_side
                                              : (roll < 95) ? pop_side
                                                            : all_ops[$urandom_range(0, 3)];
                endcase
                queue_op(op, pick_word());
                random_ops++;
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_stack_ops.size() != 0 || i_in_valid || predicted_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("** dual_stack_shared_memory: PASSED **");
        end else begin
            $display("** dual_stack_shared_memory: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/dss_pkg.sv
src/dss_ctrl.sv
src/dss_dp.sv
src/dual_stack_shared_memory.sv
src/dss_checker.sv
bench/dual_stack_shared_memory_tb.sv
